/* rtl/ycbcr_color_convert_luma_gain_defines.svh */
// ----------------------------------------------------------------------------
// ycbcr_color_convert_luma_gain_defines
// Assertion macros used by the checker file of the colour converter.
// ----------------------------------------------------------------------------
`ifndef YCBCR_COLOR_CONVERT_LUMA_GAIN_DEFINES_SVH
`define YCBCR_COLOR_CONVERT_LUMA_GAIN_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define YCCG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define YCCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/yccg_pkg.sv */
// ----------------------------------------------------------------------------
// yccg_pkg
// Shared types and constants of the YCbCr colour converter with luma gain.
// ----------------------------------------------------------------------------
package yccg_pkg;

   localparam int COEF_FRAC_BITS_DEFAULT = 16;

   localparam int PIX_WIDTH   = 8;
   localparam int MODE_WIDTH  = 2;
   localparam int GAIN_WIDTH  = 9;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 9;

   typedef logic [PIX_WIDTH-1:0]      pixel_type;
   typedef logic [MODE_WIDTH-1:0]     mode_type;
   typedef logic [GAIN_WIDTH-1:0]     gain_type;
   typedef logic [CSR_IDX_WIDTH-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;

   // conversion modes; the unused code behaves as round trip
   localparam mode_type MODE_FORWARD    = 2'd0;
   localparam mode_type MODE_INVERSE    = 2'd1;
   localparam mode_type MODE_ROUND_TRIP = 2'd2;

   // register indexes
   localparam csr_idx_type CSR_MODE = 8'd0;
   localparam csr_idx_type CSR_GAIN = 8'd1;

   localparam mode_type MODE_RESET = MODE_ROUND_TRIP;
   localparam gain_type GAIN_RESET = 9'd179;

endpackage

/* rtl/ycbcr_color_convert_luma_gain.sv */
// ----------------------------------------------------------------------------
// ycbcr_color_convert_luma_gain
// Per-pixel BGR <-> full-range BT.601 YCbCr conversion with a luma gain.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and passes it through the registered stages (input
// products, forward sums, inverse products / luma scaling, output sums and
// saturation into the response register). The whole pipeline advances
// together: it moves whenever the response register is empty or being taken,
// so req_ready follows rsp_ready combinationally and throughput is one pixel
// per cycle while the consumer keeps rsp_ready high. Mode and gain are
// sampled directly by the stages and must only change while no pixel is in
// flight. Writes to csr are always accepted; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module ycbcr_color_convert_luma_gain
   import yccg_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  pixel_type    req_chan_a,
   input  pixel_type    req_chan_b,
   input  pixel_type    req_chan_c,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pixel_type    rsp_res_a,
   output pixel_type    rsp_res_b,
   output pixel_type    rsp_res_c,

   input  logic         csr_valid,
   output logic         csr_ready,
   input  csr_idx_type  csr_index,
   input  csr_data_type csr_data
);

   localparam int F   = COEF_FRAC_BITS;
   localparam int CW  = F + 1;         // coefficient width, unsigned
   localparam int PW  = CW + 8;        // forward product width
   localparam int IPW = CW + 10;       // inverse product width, signed
   localparam int YW  = F + 9;         // fixed-point luma width
   localparam int SW  = F + 12;        // sum width, signed

   localparam logic [CW-1:0] K_Y_R  = CW'(((longint'(2990)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_Y_G  = CW'(((longint'(5870)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_Y_B  = CW'(((longint'(1140)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_CB_R = CW'(((longint'(1687)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_CB_G = CW'(((longint'(3313)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_HALF = CW'(((longint'(5000)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_CR_G = CW'(((longint'(4187)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_CR_B = CW'(((longint'(813)   << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_R_CR = CW'(((longint'(14020) << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_G_CB = CW'(((longint'(3441)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_G_CR = CW'(((longint'(7139)  << F) + 5000) / 10000);
   localparam logic [CW-1:0] K_B_CB = CW'(((longint'(17718) << F) + 5000) / 10000);

   localparam logic signed [SW-1:0] CHROMA_OFS = SW'(longint'(128) << F);

   // truncate toward zero, clamp to 0..255
   function automatic pixel_type sat_pix(input logic signed [SW-1:0] v);
      pixel_type r;
      if (v <= 0) begin
         r = '0;
      end else if (v[SW-1:F+8] != '0) begin
         r = '1;
      end else begin
         r = v[F+7:F];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- config
   mode_type mode_ff, mode_in;
   gain_type gain_ff, gain_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      gain_in = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE: mode_in = csr_data[MODE_WIDTH-1:0];
            CSR_GAIN: gain_in = csr_data[GAIN_WIDTH-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         mode_ff <= mode_in;
         gain_ff <= gain_in;
      end
   end

   // -------------------------------------------------------------- pipeline
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: forward products
   logic v1_ff, v1_in;
   pixel_type a1_ff, b1_ff, c1_ff, a1_in, b1_in, c1_in;
   logic [PW-1:0] pyr_ff, pyg_ff, pyb_ff, pcbr_ff, pcbg_ff, pcbb_ff;
   logic [PW-1:0] pcrr_ff, pcrg_ff, pcrb_ff;
   logic [PW-1:0] pyr_in, pyg_in, pyb_in, pcbr_in, pcbg_in, pcbb_in;
   logic [PW-1:0] pcrr_in, pcrg_in, pcrb_in;

   always_comb begin
      v1_in   = req_valid;
      a1_in   = req_chan_a;
      b1_in   = req_chan_b;
      c1_in   = req_chan_c;
      pyr_in  = PW'(K_Y_R)  * PW'(req_chan_c);
      pyg_in  = PW'(K_Y_G)  * PW'(req_chan_b);
      pyb_in  = PW'(K_Y_B)  * PW'(req_chan_a);
      pcbr_in = PW'(K_CB_R) * PW'(req_chan_c);
      pcbg_in = PW'(K_CB_G) * PW'(req_chan_b);
      pcbb_in = PW'(K_HALF) * PW'(req_chan_a);
      pcrr_in = PW'(K_HALF) * PW'(req_chan_c);
      pcrg_in = PW'(K_CR_G) * PW'(req_chan_b);
      pcrb_in = PW'(K_CR_B) * PW'(req_chan_a);
   end

   // stage 2: forward sums, truncated luma and chroma
   logic v2_ff, v2_in;
   pixel_type y2_ff, cb2_ff, cr2_ff, y2_in, cb2_in, cr2_in;
   logic signed [SW-1:0] ysum, cbsum, crsum;

   always_comb begin
      ysum  = $signed(SW'(pyr_ff)) + $signed(SW'(pyg_ff)) + $signed(SW'(pyb_ff));
      cbsum = $signed(SW'(pcbb_ff)) + CHROMA_OFS
            - $signed(SW'(pcbr_ff)) - $signed(SW'(pcbg_ff));
      crsum = $signed(SW'(pcrr_ff)) + CHROMA_OFS
            - $signed(SW'(pcrg_ff)) - $signed(SW'(pcrb_ff));
      v2_in = v1_ff;
      if (mode_ff == MODE_INVERSE) begin
         y2_in  = a1_ff;
         cb2_in = b1_ff;
         cr2_in = c1_ff;
      end else begin
         y2_in  = sat_pix(ysum);
         cb2_in = sat_pix(cbsum);
         cr2_in = sat_pix(crsum);
      end
   end

   // stage 3: fixed-point luma and chroma products of the inverse step
   logic v3_ff, v3_in;
   pixel_type y3_ff, cb3_ff, cr3_ff;
   logic [YW-1:0] yfix_ff, yfix_in;
   logic signed [IPW-1:0] prcr_ff, pgcb_ff, pgcr_ff, pbcb_ff;
   logic signed [IPW-1:0] prcr_in, pgcb_in, pgcr_in, pbcb_in;
   logic signed [8:0] dcb, dcr;
   logic [16:0] yscaled;

   always_comb begin
      v3_in   = v2_ff;
      dcb     = $signed({1'b0, cb2_ff}) - 9'sd128;
      dcr     = $signed({1'b0, cr2_ff}) - 9'sd128;
      yscaled = 17'(y2_ff) * 17'(gain_ff);
      if (mode_ff == MODE_INVERSE) begin
         yfix_in = YW'(y2_ff) << F;
      end else begin
         yfix_in = YW'(yscaled) << (F - 8);
      end
      prcr_in = IPW'($signed({1'b0, K_R_CR})) * IPW'(dcr);
      pgcb_in = IPW'($signed({1'b0, K_G_CB})) * IPW'(dcb);
      pgcr_in = IPW'($signed({1'b0, K_G_CR})) * IPW'(dcr);
      pbcb_in = IPW'($signed({1'b0, K_B_CB})) * IPW'(dcb);
   end

   // stage 4: inverse sums, saturation, response register
   logic rsp_valid_ff, rsp_valid_in;
   pixel_type res_a_ff, res_b_ff, res_c_ff, res_a_in, res_b_in, res_c_in;
   logic signed [SW-1:0] ys, bsum, gsum, rsum;

   always_comb begin
      ys   = $signed(SW'(yfix_ff));
      bsum = ys + SW'(pbcb_ff);
      gsum = ys - SW'(pgcb_ff) - SW'(pgcr_ff);
      rsum = ys + SW'(prcr_ff);
      rsp_valid_in = v3_ff;
      if (mode_ff == MODE_FORWARD) begin
         res_a_in = y3_ff;
         res_b_in = cb3_ff;
         res_c_in = cr3_ff;
      end else begin
         res_a_in = sat_pix(bsum);
         res_b_in = sat_pix(gsum);
         res_c_in = sat_pix(rsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         c1_ff   <= c1_in;
         pyr_ff  <= pyr_in;
         pyg_ff  <= pyg_in;
         pyb_ff  <= pyb_in;
         pcbr_ff <= pcbr_in;
         pcbg_ff <= pcbg_in;
         pcbb_ff <= pcbb_in;
         pcrr_ff <= pcrr_in;
         pcrg_ff <= pcrg_in;
         pcrb_ff <= pcrb_in;

         y2_ff   <= y2_in;
         cb2_ff  <= cb2_in;
         cr2_ff  <= cr2_in;

         y3_ff   <= y2_ff;
         cb3_ff  <= cb2_ff;
         cr3_ff  <= cr2_ff;
         yfix_ff <= yfix_in;
         prcr_ff <= prcr_in;
         pgcb_ff <= pgcb_in;
         pgcr_ff <= pgcr_in;
         pbcb_ff <= pbcb_in;

         res_a_ff <= res_a_in;
         res_b_ff <= res_b_in;
         res_c_ff <= res_c_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res_a = res_a_ff;
   assign rsp_res_b = res_b_ff;
   assign rsp_res_c = res_c_ff;

endmodule

/* rtl/yccg_checker.sv */
// ----------------------------------------------------------------------------
// yccg_checker
// Port-level checks of the colour converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "ycbcr_color_convert_luma_gain_defines.svh"

module yccg_checker
   import yccg_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input pixel_type rsp_res_a,
   input pixel_type rsp_res_b,
   input pixel_type rsp_res_c,
   input logic      csr_valid,
   input logic      csr_ready
);

   // a stalled response keeps its pixel
   `YCCG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_res_a) && $stable(rsp_res_b) && $stable(rsp_res_c), "stalled response changed")

   // reset leaves no response pending
   `YCCG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   // with the output free the pipeline never holds off a request
   `YCCG_ASSERT_SAME(a_no_false_stall, clock, reset, !rsp_valid || rsp_ready, req_ready, "request stalled while output free")

   // register writes are never held off
   `YCCG_ASSERT_SAME(a_csr_ready, clock, reset, csr_valid || req_valid, csr_ready, "register write stalled")

endmodule

bind ycbcr_color_convert_luma_gain yccg_checker u_yccg_checker (.*);
